### hw/rtl/ttl_block_table_with_eviction_assert.svh
// Assertion macros used by the sequencer module.
// Each macro takes a label, the clock, the active-low reset, a condition
// and the property that must follow from it.
`ifndef TTL_BLOCK_TABLE_WITH_EVICTION_ASSERT_SVH
`define TTL_BLOCK_TABLE_WITH_EVICTION_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define TTBE_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("same-cycle implication violated");

// The consequence must hold in the cycle after the condition.
`define TTBE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle implication violated");

`endif

### hw/rtl/ttbe_pkg.sv
`timescale 1ns / 1ps

package ttbe_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 32;
	localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNTW = $clog2(TABLE_DEPTH + 1);

	// Field widths.
	localparam int DATAW = 32;
	localparam int OPW = 2;
	localparam int CAPW = 6;
	localparam int POLW = 3;
	localparam int PICKW = 5;
	localparam int STATW = 3;
	localparam int OCNTW = 6;
	localparam int CFG_IDXW = 1;
	localparam int CFG_DW = 6;

	// Common width for comparing counts against limits and indexes.
	localparam int LIMW0 = (CNTW > CAPW) ? CNTW : CAPW;
	localparam int LIMW = (LIMW0 > PICKW) ? LIMW0 : PICKW;

	// Register indexes.
	localparam logic [CFG_IDXW-1:0] REG_CAPACITY = 1'd0;
	localparam logic [CFG_IDXW-1:0] REG_POLICY = 1'd1;

	// Register reset values.
	localparam logic [CAPW-1:0] CAP_RESET = 6'd32;

	// Operation codes.
	localparam logic [OPW-1:0] OP_ADD = 2'd0;
	localparam logic [OPW-1:0] OP_REMOVE = 2'd1;
	localparam logic [OPW-1:0] OP_TICK = 2'd2;

	// Removal policies.
	localparam logic [POLW-1:0] POL_NEVER = 3'd0;
	localparam logic [POLW-1:0] POL_NEWEST = 3'd1;
	localparam logic [POLW-1:0] POL_OLDEST = 3'd2;
	localparam logic [POLW-1:0] POL_INDEXED = 3'd3;
	localparam logic [POLW-1:0] POL_LARGEST = 3'd4;
	localparam logic [POLW-1:0] POL_SMALLEST = 3'd5;

	// Result status codes.
	localparam logic [STATW-1:0] STAT_OK = 3'd0;
	localparam logic [STATW-1:0] STAT_FULL = 3'd1;
	localparam logic [STATW-1:0] STAT_NONE = 3'd2;
	localparam logic [STATW-1:0] STAT_RANGE = 3'd3;
	localparam logic [STATW-1:0] STAT_POLICY = 3'd4;

	// Control broadcast from the sequencer to every cell of the ring.
	typedef struct packed {
		logic shift;
		logic wen;
		logic [IDXW-1:0] widx;
		logic [DATAW-1:0] wsize;
		logic [DATAW-1:0] wttl;
	} cell_ctl_t;

endpackage

### hw/rtl/ttl_block_table_with_eviction.sv
`timescale 1ns / 1ps
// Add, immediate errors and the unused opcode go from the request straight to the response
// state. Remove by newest, oldest or index and tick first make one ring rotation (PASS).
// Remove by largest or smallest size makes a search rotation (SCAN), then the erase pass.
// One request is worked at a time; the next is taken once the result sits in the output
// register; a result waits in the response state while the output register still holds one.
// Reset clears the entry count and loads the register defaults; entry contents stay undefined.
module ttl_block_table_with_eviction (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ttbe_pkg::CFG_IDXW-1:0] cfg_index,
	input logic [ttbe_pkg::CFG_DW-1:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// opcode[1:0], entry_size[33:2], entry_ttl[65:34], pick_index[70:66], zero fill [71]
	input logic [71:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// status[2:0], entry_count[8:3], removed_size[40:9], pruned_count[46:41], zero fill [47]
	output logic [47:0] m_tdata
);

	ttbe_pkg::cell_ctl_t ctl;
	logic [ttbe_pkg::DATAW-1:0] cell_size [ttbe_pkg::TABLE_DEPTH];
	logic [ttbe_pkg::DATAW-1:0] cell_ttl [ttbe_pkg::TABLE_DEPTH];
	logic [ttbe_pkg::STATW-1:0] status;
	logic [ttbe_pkg::OCNTW-1:0] entry_count;
	logic [ttbe_pkg::DATAW-1:0] removed_size;
	logic [ttbe_pkg::OCNTW-1:0] pruned_count;

	// Ring of cells; each takes the contents of the next one on a shift.
	for (genvar g = 0; g < ttbe_pkg::TABLE_DEPTH; g++) begin : g_cell
		localparam int NXT = (g + 1) % ttbe_pkg::TABLE_DEPTH;
		ttbe_cell u_cell (
			.clk(clk),
			.ctl(ctl),
			.idx(ttbe_pkg::IDXW'(g)),
			.nbr_size(cell_size[NXT]),
			.nbr_ttl(cell_ttl[NXT]),
			.size(cell_size[g]),
			.ttl(cell_ttl[g])
		);
	end

	// Sequencer, configuration registers and result register.
	ttbe_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.opcode(s_tdata[1:0]),
		.entry_size(s_tdata[33:2]),
		.entry_ttl(s_tdata[65:34]),
		.pick_index(s_tdata[70:66]),
		.head_size(cell_size[0]),
		.head_ttl(cell_ttl[0]),
		.ctl(ctl),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.status(status),
		.entry_count(entry_count),
		.removed_size(removed_size),
		.pruned_count(pruned_count)
	);

	assign m_tdata = {1'b0, pruned_count, removed_size, entry_count, status};

endmodule

### hw/rtl/ttbe_cell.sv
`timescale 1ns / 1ps

module ttbe_cell (
	input logic clk,
	input ttbe_pkg::cell_ctl_t ctl,
	input logic [ttbe_pkg::IDXW-1:0] idx,
	input logic [ttbe_pkg::DATAW-1:0] nbr_size,
	input logic [ttbe_pkg::DATAW-1:0] nbr_ttl,
	output logic [ttbe_pkg::DATAW-1:0] size,
	output logic [ttbe_pkg::DATAW-1:0] ttl
);

	logic [ttbe_pkg::DATAW-1:0] size_q;
	logic [ttbe_pkg::DATAW-1:0] ttl_q;

	// A write addressed to this cell wins over the shift from the neighbor.
	always_ff @(posedge clk) begin
		if (ctl.wen && (ctl.widx == idx)) begin
			size_q <= ctl.wsize;
			ttl_q <= ctl.wttl;
		end else if (ctl.shift) begin
			size_q <= nbr_size;
			ttl_q <= nbr_ttl;
		end
	end

	assign size = size_q;
	assign ttl = ttl_q;

endmodule

### hw/rtl/ttbe_seq.sv
`timescale 1ns / 1ps

module ttbe_seq (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ttbe_pkg::CFG_IDXW-1:0] cfg_index,
	input logic [ttbe_pkg::CFG_DW-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [ttbe_pkg::OPW-1:0] opcode,
	input logic [ttbe_pkg::DATAW-1:0] entry_size,
	input logic [ttbe_pkg::DATAW-1:0] entry_ttl,
	input logic [ttbe_pkg::PICKW-1:0] pick_index,
	input logic [ttbe_pkg::DATAW-1:0] head_size,
	input logic [ttbe_pkg::DATAW-1:0] head_ttl,
	output ttbe_pkg::cell_ctl_t ctl,
	output logic out_valid,
	input logic out_ready,
	output logic [ttbe_pkg::STATW-1:0] status,
	output logic [ttbe_pkg::OCNTW-1:0] entry_count,
	output logic [ttbe_pkg::DATAW-1:0] removed_size,
	output logic [ttbe_pkg::OCNTW-1:0] pruned_count
);

	`include "ttl_block_table_with_eviction_assert.svh"

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_PASS = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	localparam logic [ttbe_pkg::IDXW-1:0] LAST_IDX = ttbe_pkg::IDXW'(ttbe_pkg::TABLE_DEPTH - 1);
	localparam logic [ttbe_pkg::LIMW-1:0] DEPTH_LIM = ttbe_pkg::LIMW'(ttbe_pkg::TABLE_DEPTH);

	logic [1:0] state_q;
	logic [ttbe_pkg::CAPW-1:0] cap_q;
	logic [ttbe_pkg::POLW-1:0] pol_q;
	logic [ttbe_pkg::CNTW-1:0] count_q;
	logic [ttbe_pkg::CNTW-1:0] drops_q;
	logic [ttbe_pkg::IDXW-1:0] step_q;
	logic [ttbe_pkg::IDXW-1:0] pos_q;
	logic [ttbe_pkg::DATAW-1:0] best_q;
	logic tick_q;
	logic [ttbe_pkg::STATW-1:0] res_status_q;
	logic [ttbe_pkg::DATAW-1:0] removed_q;
	logic out_valid_q;
	logic [ttbe_pkg::STATW-1:0] out_status_q;
	logic [ttbe_pkg::OCNTW-1:0] out_count_q;
	logic [ttbe_pkg::DATAW-1:0] out_removed_q;
	logic [ttbe_pkg::OCNTW-1:0] out_pruned_q;

	logic accept;
	logic table_full;
	logic [ttbe_pkg::LIMW-1:0] limit;
	logic [ttbe_pkg::LIMW-1:0] count_ext;
	logic live;
	logic step_last;
	logic [ttbe_pkg::DATAW-1:0] ttl_dec;
	logic [ttbe_pkg::DATAW-1:0] pass_ttl;
	logic drop;
	logic keep;
	logic better;
	logic resp_load;
	logic [ttbe_pkg::IDXW-1:0] wptr;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	// Effective capacity is the smaller of the register and the table depth.
	assign count_ext = ttbe_pkg::LIMW'(count_q);
	assign limit = (ttbe_pkg::LIMW'(cap_q) < DEPTH_LIM) ? ttbe_pkg::LIMW'(cap_q) : DEPTH_LIM;
	assign table_full = (count_ext >= limit);

	// The ring rotates once per pass; the head cell holds the entry at position step_q.
	assign live = (ttbe_pkg::CNTW'(step_q) < count_q);
	assign step_last = (step_q == LAST_IDX);

	// Kept entries land at the slot that rotates into their compacted position.
	assign wptr = LAST_IDX - drops_q[ttbe_pkg::IDXW-1:0];

	// Positive time-to-live counts down; zero and negative values stay.
	assign ttl_dec = (!head_ttl[ttbe_pkg::DATAW-1] && (head_ttl != '0)) ?
		(head_ttl - ttbe_pkg::DATAW'(1)) : head_ttl;
	assign pass_ttl = tick_q ? ttl_dec : head_ttl;
	assign drop = live && (tick_q ? (ttl_dec == '0) : (step_q == pos_q));
	assign keep = live && !drop;

	// Search compare for the first largest or first smallest size.
	assign better = (pol_q == ttbe_pkg::POL_LARGEST) ? (head_size > best_q) : (head_size < best_q);

	assign resp_load = (state_q == S_RESP) && (!out_valid_q || out_ready);

	// Cell control: add writes the fill slot, scan shifts, pass shifts and rewrites.
	always_comb begin
		ctl.shift = 1'b0;
		ctl.wen = 1'b0;
		ctl.widx = wptr;
		ctl.wsize = head_size;
		ctl.wttl = pass_ttl;
		case (state_q)
			S_IDLE: begin
				if (accept && (opcode == ttbe_pkg::OP_ADD) && !table_full) begin
					ctl.wen = 1'b1;
					ctl.widx = ttbe_pkg::IDXW'(count_q);
					ctl.wsize = entry_size;
					ctl.wttl = entry_ttl;
				end
			end
			S_SCAN: begin
				ctl.shift = 1'b1;
			end
			S_PASS: begin
				ctl.shift = 1'b1;
				ctl.wen = keep;
			end
			default: begin
				ctl.shift = 1'b0;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= ttbe_pkg::CAP_RESET;
			pol_q <= ttbe_pkg::POL_NEVER;
		end else if (cfg_we) begin
			if (cfg_index == ttbe_pkg::REG_CAPACITY) begin
				cap_q <= cfg_data[ttbe_pkg::CAPW-1:0];
			end else if (cfg_index == ttbe_pkg::REG_POLICY) begin
				pol_q <= cfg_data[ttbe_pkg::POLW-1:0];
			end
		end
	end

	// Operation sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			drops_q <= '0;
			step_q <= '0;
			pos_q <= '0;
			best_q <= '0;
			tick_q <= 1'b0;
			res_status_q <= ttbe_pkg::STAT_OK;
			removed_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						drops_q <= '0;
						step_q <= '0;
						tick_q <= 1'b0;
						res_status_q <= ttbe_pkg::STAT_OK;
						removed_q <= '0;
						state_q <= S_RESP;
						if (opcode == ttbe_pkg::OP_ADD) begin
							if (table_full) begin
								res_status_q <= ttbe_pkg::STAT_FULL;
							end else begin
								count_q <= count_q + ttbe_pkg::CNTW'(1);
							end
						end else if (opcode == ttbe_pkg::OP_REMOVE) begin
							if ((pol_q == ttbe_pkg::POL_NEVER) || (count_q == '0)) begin
								res_status_q <= ttbe_pkg::STAT_NONE;
							end else begin
								case (pol_q)
									ttbe_pkg::POL_NEWEST: begin
										pos_q <= ttbe_pkg::IDXW'(count_q - ttbe_pkg::CNTW'(1));
										state_q <= S_PASS;
									end
									ttbe_pkg::POL_OLDEST: begin
										pos_q <= '0;
										state_q <= S_PASS;
									end
									ttbe_pkg::POL_INDEXED: begin
										if (ttbe_pkg::LIMW'(pick_index) >= count_ext) begin
											res_status_q <= ttbe_pkg::STAT_RANGE;
										end else begin
											pos_q <= ttbe_pkg::IDXW'(pick_index);
											state_q <= S_PASS;
										end
									end
									ttbe_pkg::POL_LARGEST, ttbe_pkg::POL_SMALLEST: begin
										state_q <= S_SCAN;
									end
									default: begin
										res_status_q <= ttbe_pkg::STAT_POLICY;
									end
								endcase
							end
						end else if (opcode == ttbe_pkg::OP_TICK) begin
							tick_q <= 1'b1;
							state_q <= S_PASS;
						end
					end
				end
				S_SCAN: begin
					// One full rotation to find the first extreme size.
					if (step_q == '0) begin
						best_q <= head_size;
						pos_q <= '0;
					end else if (live && better) begin
						best_q <= head_size;
						pos_q <= step_q;
					end
					step_q <= step_q + ttbe_pkg::IDXW'(1);
					if (step_last) begin
						step_q <= '0;
						state_q <= S_PASS;
					end
				end
				S_PASS: begin
					// One full rotation that drops and compacts entries.
					if (drop && !tick_q) begin
						removed_q <= head_size;
					end
					drops_q <= drops_q + ttbe_pkg::CNTW'(drop);
					step_q <= step_q + ttbe_pkg::IDXW'(1);
					if (step_last) begin
						count_q <= count_q - drops_q - ttbe_pkg::CNTW'(drop);
						step_q <= '0;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (resp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register; it frees the sequencer while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			out_status_q <= res_status_q;
			out_count_q <= ttbe_pkg::OCNTW'(count_q);
			out_removed_q <= removed_q;
			out_pruned_q <= tick_q ? ttbe_pkg::OCNTW'(drops_q) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign entry_count = out_count_q;
	assign removed_size = out_removed_q;
	assign pruned_count = out_pruned_q;

	`TTBE_ASSERT_NEXT(a_add_count, clk, arst_n, accept && (opcode == ttbe_pkg::OP_ADD) && !table_full, count_q == $past(count_q) + ttbe_pkg::CNTW'(1))
	`TTBE_ASSERT_NEXT(a_pass_ends, clk, arst_n, (state_q == S_PASS) && step_last, state_q == S_RESP)
	`TTBE_ASSERT_IMPLY(a_drops_bound, clk, arst_n, state_q == S_PASS, drops_q <= count_q)
	`TTBE_ASSERT_NEXT(a_resp_load, clk, arst_n, resp_load, out_valid_q && (state_q == S_IDLE))

endmodule

### tb/ttl_block_table_with_eviction_tb.sv
`timescale 1ns / 1ps

module ttl_block_table_with_eviction_tb;
	import ttbe_pkg::*;

	// Codes the package leaves unnamed.
	localparam logic [OPW-1:0] OP_UNUSED = 2'd3;
	localparam logic [POLW-1:0] POL_BAD_LO = 3'd6;
	localparam logic [POLW-1:0] POL_BAD_HI = 3'd7;

	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 8;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 70;

	// One request, op in the lowest bits.
	typedef struct packed {
		logic [PICKW-1:0] pick;
		logic [DATAW-1:0] ttl;
		logic [DATAW-1:0] size;
		logic [OPW-1:0] op;
	} table_req_t;

	// One result, status in the lowest bits.
	typedef struct packed {
		logic [OCNTW-1:0] pruned;
		logic [DATAW-1:0] removed;
		logic [OCNTW-1:0] count;
		logic [STATW-1:0] status;
	} table_rsp_t;

	typedef struct {
		bit reconf;
		logic [CAPW-1:0] cap;
		logic [POLW-1:0] pol;
		table_req_t rq;
		bit typed;
		table_rsp_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDXW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [71:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [47:0] m_tdata;

	// Shadow copy of the table and its registers.
	logic [DATAW-1:0] shadow_size [TABLE_DEPTH];
	logic [DATAW-1:0] shadow_ttl [TABLE_DEPTH];
	int held;
	logic [CAPW-1:0] cap_reg;
	logic [POLW-1:0] pol_reg;

	table_rsp_t due_outcomes [$];
	plan_row_t plan [$];
	int mismatches;
	bit quiet_phase;

	ttl_block_table_with_eviction dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Apply one operation to the shadow table and return its outcome.
	function automatic table_rsp_t apply_table_op(table_req_t rq);
		table_rsp_t rs;
		int limit;
		int pos;
		int kept;
		logic [DATAW-1:0] t;
		rs = '0;
		case (rq.op)
			OP_ADD: begin
				limit = (int'(cap_reg) < TABLE_DEPTH) ? int'(cap_reg) : TABLE_DEPTH;
				if (held >= limit) begin
					rs.status = STAT_FULL;
				end else begin
					shadow_size[held] = rq.size;
					shadow_ttl[held] = rq.ttl;
					held++;
				end
			end
			OP_REMOVE: begin
				if (pol_reg == POL_NEVER || held == 0) begin
					rs.status = STAT_NONE;
				end else begin
					pos = -1;
					case (pol_reg)
						POL_NEWEST: pos = held - 1;
						POL_OLDEST: pos = 0;
						POL_INDEXED: begin
							if (int'(rq.pick) >= held) rs.status = STAT_RANGE;
							else pos = int'(rq.pick);
						end
						POL_LARGEST: begin
							pos = 0;
							for (int i = 1; i < held; i++)
								if (shadow_size[i] > shadow_size[pos]) pos = i;
						end
						POL_SMALLEST: begin
							pos = 0;
							for (int i = 1; i < held; i++)
								if (shadow_size[i] < shadow_size[pos]) pos = i;
						end
						default: rs.status = STAT_POLICY;
					endcase
					// Take the chosen entry out and close the gap.
					if (pos >= 0) begin
						rs.removed = shadow_size[pos];
						for (int i = pos; i + 1 < held; i++) begin
							shadow_size[i] = shadow_size[i + 1];
							shadow_ttl[i] = shadow_ttl[i + 1];
						end
						held--;
					end
				end
			end
			OP_TICK: begin
				// Count down positive lifetimes, then compact out the expired ones.
				kept = 0;
				for (int i = 0; i < held; i++) begin
					t = shadow_ttl[i];
					if (t != 0 && !t[DATAW-1]) t = t - DATAW'(1);
					if (t == 0) begin
						rs.pruned = rs.pruned + OCNTW'(1);
					end else begin
						shadow_size[kept] = shadow_size[i];
						shadow_ttl[kept] = t;
						kept++;
					end
				end
				held = kept;
			end
			default: ;
		endcase
		rs.count = OCNTW'(held);
		return rs;
	endfunction

	function automatic table_rsp_t rsp(logic [STATW-1:0] st, logic [OCNTW-1:0] cnt,
			logic [DATAW-1:0] rem, logic [OCNTW-1:0] prn);
		table_rsp_t r;
		r.status = st;
		r.count = cnt;
		r.removed = rem;
		r.pruned = prn;
		return r;
	endfunction

	function automatic plan_row_t prow(bit reconf, logic [CAPW-1:0] cap, logic [POLW-1:0] pol,
			logic [OPW-1:0] op, logic [DATAW-1:0] size, logic [DATAW-1:0] ttl,
			logic [PICKW-1:0] pick, bit typed, table_rsp_t want);
		plan_row_t r;
		r.reconf = reconf;
		r.cap = cap;
		r.pol = pol;
		r.rq.op = op;
		r.rq.size = size;
		r.rq.ttl = ttl;
		r.rq.pick = pick;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_gap();
		int r;
		if (quiet_phase) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [DATAW-1:0] rand_size();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return $urandom_range(0, 15);
		if (r == 4) return 32'hFFFF_FFFF;
		if (r == 5) return 32'h0;
		return $urandom;
	endfunction

	// Mostly short lifetimes so that ticks expire entries, plus never-expiring ones.
	function automatic logic [DATAW-1:0] rand_ttl();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10) return $urandom_range(0, 6);
		if (r < 13) return $urandom | 32'h8000_0000;
		if (r == 13) return 32'hFFFF_FFFF;
		if (r == 14) return 32'h7FFF_FFFF;
		if (r == 15) return 32'h8000_0000;
		if (r == 16) return 32'h0;
		return $urandom;
	endfunction

	// Present one request and wait until it is taken; the outcome is queued on acceptance.
	task automatic issue_request(input table_req_t rq, input bit typed, input table_rsp_t want);
		int gap;
		table_rsp_t predicted;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, rq};
		do @(posedge clk); while (s_tready !== 1'b1);
		predicted = apply_table_op(rq);
		due_outcomes.push_back(typed ? want : predicted);
	endtask

	// Hold off the sender until every outstanding result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (due_outcomes.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write both registers back to back; only called while the block is idle.
	task automatic write_config(input logic [CAPW-1:0] cap, input logic [POLW-1:0] pol);
		cfg_we <= 1'b1;
		cfg_index <= REG_CAPACITY;
		cfg_data <= cap;
		@(posedge clk);
		cfg_index <= REG_POLICY;
		cfg_data <= CFG_DW'(pol);
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = cap;
		pol_reg = pol;
	endtask

	task automatic check_field(input string fname, input logic [DATAW-1:0] want,
			input logic [DATAW-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t %s: expected %0h, got %0h", $time, fname, want, got);
		end
	endtask

	// Result side: compare every accepted result with the oldest outcome due.
	always @(posedge clk) begin : result_check
		table_rsp_t got;
		table_rsp_t want;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got = m_tdata[46:0];
			if (due_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t unexpected result %0h", $time, m_tdata);
			end else begin
				want = due_outcomes[0];
				due_outcomes.delete(0);
				check_field("status", DATAW'(want.status), DATAW'(got.status));
				check_field("entry_count", DATAW'(want.count), DATAW'(got.count));
				check_field("removed_size", want.removed, got.removed);
				check_field("pruned_count", DATAW'(want.pruned), DATAW'(got.pruned));
			end
		end
	end

	// Result side back pressure.
	initial begin : result_stall
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = idle_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Watchdog on cycles with no transfer at all.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
					(m_tvalid === 1'b1 && m_tready === 1'b1) || cfg_we === 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("ttl_block_table_with_eviction: mismatch");
		$finish;
	end

	// Stimulus.
	initial begin : stimulus
		int caps [PHASES];
		int add_pct;
		int rem_pct;
		int r;
		table_req_t rq;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatches = 0;
		quiet_phase = 1'b0;
		held = 0;
		cap_reg = CAP_RESET;
		pol_reg = POL_NEVER;

		// Directed walk: empty table, field extremes, every policy and error.
		plan.push_back(prow(0, 0, POL_NEVER, OP_REMOVE, 0, 0, 0, 1, rsp(STAT_NONE, 0, 0, 0)));
		plan.push_back(prow(0, 0, POL_NEVER, OP_TICK, 0, 0, 0, 1, rsp(STAT_OK, 0, 0, 0)));
		plan.push_back(prow(0, 0, POL_NEVER, OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31, 1,
			rsp(STAT_OK, 0, 0, 0)));
		plan.push_back(prow(0, 0, POL_NEVER, OP_ADD, 0, 0, 0, 1, rsp(STAT_OK, 1, 0, 0)));
		plan.push_back(prow(0, 0, POL_NEVER, OP_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 1,
			rsp(STAT_OK, 2, 0, 0)));
		plan.push_back(prow(0, 0, POL_NEVER, OP_ADD, 1, 32'h8000_0000, 0, 1,
			rsp(STAT_OK, 3, 0, 0)));
		plan.push_back(prow(0, 0, POL_NEVER, OP_ADD, 5, 32'hFFFF_FFFF, 0, 1,
			rsp(STAT_OK, 4, 0, 0)));
		plan.push_back(prow(0, 0, POL_NEVER, OP_ADD, 32'h8000_0000, 1, 0, 1,
			rsp(STAT_OK, 5, 0, 0)));
		plan.push_back(prow(0, 0, POL_NEVER, OP_REMOVE, 0, 0, 0, 1, rsp(STAT_NONE, 5, 0, 0)));
		// Zero lifetime and lifetime one both expire on this tick.
		plan.push_back(prow(0, 0, POL_NEVER, OP_TICK, 0, 0, 0, 1, rsp(STAT_OK, 3, 0, 2)));
		plan.push_back(prow(1, 32, POL_BAD_LO, OP_REMOVE, 0, 0, 0, 1,
			rsp(STAT_POLICY, 3, 0, 0)));
		plan.push_back(prow(1, 32, POL_BAD_HI, OP_REMOVE, 0, 0, 0, 1,
			rsp(STAT_POLICY, 3, 0, 0)));
		plan.push_back(prow(1, 32, POL_LARGEST, OP_REMOVE, 0, 0, 0, 1,
			rsp(STAT_OK, 2, 32'hFFFF_FFFF, 0)));
		plan.push_back(prow(1, 32, POL_SMALLEST, OP_REMOVE, 0, 0, 0, 1,
			rsp(STAT_OK, 1, 1, 0)));
		plan.push_back(prow(1, 32, POL_INDEXED, OP_REMOVE, 0, 0, 31, 1,
			rsp(STAT_RANGE, 1, 0, 0)));
		plan.push_back(prow(0, 0, POL_NEVER, OP_REMOVE, 0, 0, 1, 1, rsp(STAT_RANGE, 1, 0, 0)));
		plan.push_back(prow(1, 1, POL_INDEXED, OP_ADD, 7, 2, 0, 1, rsp(STAT_FULL, 1, 0, 0)));
		plan.push_back(prow(1, 2, POL_NEWEST, OP_ADD, 7, 2, 0, 0, '0));
		plan.push_back(prow(0, 0, POL_NEVER, OP_ADD, 3, 3, 0, 1, rsp(STAT_FULL, 2, 0, 0)));
		plan.push_back(prow(0, 0, POL_NEVER, OP_REMOVE, 0, 0, 0, 1, rsp(STAT_OK, 1, 7, 0)));
		plan.push_back(prow(1, 0, POL_OLDEST, OP_ADD, 3, 3, 0, 1, rsp(STAT_FULL, 1, 0, 0)));
		plan.push_back(prow(0, 0, POL_NEVER, OP_REMOVE, 0, 0, 0, 1, rsp(STAT_OK, 0, 5, 0)));
		// An invalid policy on an empty table reports nothing removed.
		plan.push_back(prow(1, 0, POL_BAD_LO, OP_REMOVE, 0, 0, 0, 1, rsp(STAT_NONE, 0, 0, 0)));
		plan.push_back(prow(1, 63, POL_INDEXED, OP_ADD, 4, 2, 0, 0, '0));
		plan.push_back(prow(0, 0, POL_NEVER, OP_REMOVE, 0, 0, 0, 1, rsp(STAT_OK, 0, 4, 0)));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			if (plan[k].reconf) begin
				drain();
				write_config(plan[k].cap, plan[k].pol);
			end
			issue_request(plan[k].rq, plan[k].typed, plan[k].want);
		end

		// Random phases, one register setting each.
		caps = '{63, 32, 8, 1, 0, 20, 63, 3, 32, 0};
		caps[PHASES - 1] = $urandom_range(0, 63);
		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_config(CAPW'(caps[p]), POLW'(p % 8));
			quiet_phase = (p == 2 || p == 6);
			add_pct = (p == 0) ? 65 : $urandom_range(30, 60);
			rem_pct = $urandom_range(15, 30);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 3) rq.op = OP_UNUSED;
				else if (r < 3 + add_pct) rq.op = OP_ADD;
				else if (r < 3 + add_pct + rem_pct) rq.op = OP_REMOVE;
				else rq.op = OP_TICK;
				rq.size = rand_size();
				rq.ttl = rand_ttl();
				// Under the indexed policy most picks land on a held entry.
				if ($urandom_range(0, 9) < 7 && held > 0)
					rq.pick = PICKW'($urandom_range(0, held - 1));
				else
					rq.pick = PICKW'($urandom_range(0, 31));
				issue_request(rq, 1'b0, '0);
				if ((p == 1 && i == 35) || $urandom_range(0, 99) == 0)
					drain();
			end
		end

		// Let everything outstanding come back, then a little longer.
		s_tvalid <= 1'b0;
		while (due_outcomes.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_outcomes.size() == 0)
			$display("ttl_block_table_with_eviction: match");
		else
			$display("ttl_block_table_with_eviction: mismatch");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ttbe_pkg.sv
hw/rtl/ttbe_cell.sv
hw/rtl/ttbe_seq.sv
hw/rtl/ttl_block_table_with_eviction.sv
tb/ttl_block_table_with_eviction_tb.sv
